// ===== hw/rtl/nmea_sentence_receiver_macros.svh =====
// Assertion macros shared by the NMEA sentence receiver checkers.
// No dependencies; included by files that carry assertions.
`ifndef NMEA_SENTENCE_RECEIVER_MACROS_SVH
`define NMEA_SENTENCE_RECEIVER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define NSR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("nsr check failed");

// Antecedent in one cycle implies consequent in the next.
`define NSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nsr check failed");

`endif

// ===== hw/rtl/nsr_pkg.sv =====
// Types, codes and helper functions for the NMEA sentence receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package nsr_pkg;

    parameter int MAX_LENGTH = 128;

    localparam logic [7:0] MAX_LEN_C = 8'(MAX_LENGTH);
    localparam logic [7:0] LEN_LIMIT = 8'(MAX_LENGTH - 1);
    localparam logic [7:0] LEN_MIN   = 8'd10;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'd13;

    // no-link code returned for unknown types
    localparam logic [1:0] LINK_NONE = 2'd3;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_CHECKSUM = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        TY_UNKNOWN = 4'd0,
        TY_RMB     = 4'd1,
        TY_RMC     = 4'd2,
        TY_GGA     = 4'd3,
        TY_VTG     = 4'd4,
        TY_MWV     = 4'd5,
        TY_DPT     = 4'd6,
        TY_VHW     = 4'd7,
        TY_HDG     = 4'd8
    } stype_t;

    typedef enum logic [2:0] {
        CFG_NAV     = 3'd0,
        CFG_GNSS    = 3'd1,
        CFG_WIND    = 3'd2,
        CFG_DEPTH   = 3'd3,
        CFG_SPEED   = 3'd4,
        CFG_COMPASS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] nav;
        logic [1:0] gnss;
        logic [1:0] wind;
        logic [1:0] depth;
        logic [1:0] speed;
        logic [1:0] compass;
    } route_cfg_t;

    typedef struct packed {
        logic        in_sentence;
        logic [7:0]  char_count;
        logic [7:0]  running_xor;
        logic [7:0]  xor_at_star;
        logic        star_seen;
        logic [1:0]  digits_after_star;
        logic [7:0]  checksum_digits;
        logic        digit_error;
        logic [23:0] type_chars;
    } link_state_t;

    typedef struct packed {
        logic       forward;
        logic       dispatch;
        stype_t     sentence_type;
        status_t    status;
        logic [7:0] length;
    } result_t;

    // Nibble value of a hex digit; bit 4 set when the character is not one.
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (ch >= 8'h30 && ch <= 8'h39) begin
                d = ch - 8'h30;
                hex_value = {1'b0, d[3:0]};
            end else if (ch >= 8'h41 && ch <= 8'h46) begin
                d = ch - 8'h37;
                hex_value = {1'b0, d[3:0]};
            end else if (ch >= 8'h61 && ch <= 8'h66) begin
                d = ch - 8'h57;
                hex_value = {1'b0, d[3:0]};
            end else begin
                hex_value = 5'h10;
            end
        end
    endfunction

    function automatic stype_t decode_type(input logic [23:0] t);
        begin
            unique case (t)
                24'h524D42: decode_type = TY_RMB;
                24'h524D43: decode_type = TY_RMC;
                24'h474741: decode_type = TY_GGA;
                24'h565447: decode_type = TY_VTG;
                24'h4D5756: decode_type = TY_MWV;
                24'h445054: decode_type = TY_DPT;
                24'h564857: decode_type = TY_VHW;
                24'h484447: decode_type = TY_HDG;
                default:    decode_type = TY_UNKNOWN;
            endcase
        end
    endfunction

    function automatic logic [1:0] source_of(input stype_t ty, input route_cfg_t cfg);
        begin
            unique case (ty)
                TY_RMB:                 source_of = cfg.nav;
                TY_RMC, TY_GGA, TY_VTG: source_of = cfg.gnss;
                TY_MWV:                 source_of = cfg.wind;
                TY_DPT:                 source_of = cfg.depth;
                TY_VHW:                 source_of = cfg.speed;
                TY_HDG:                 source_of = cfg.compass;
                default:                source_of = LINK_NONE;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nmea_sentence_receiver.sv =====
// NMEA sentence receiver: two-link framing, checksum check and routing flags.
// Path: a character taken from the slave side passes the input register, then
// the result register, before its result appears on the master side.
// Throughput: one item per cycle; the input register stalls only when the
// output register holds a result not yet taken.
// Reset (synchronous, aresetn low): both links leave any sentence, output
// empties, routing registers return to their reset values.
// Depends on nsr_pkg and nsr_char_step.
`default_nettype none

module nmea_sentence_receiver (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tuser,   // [0] link
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,   // [1:0] status, [5:2] sentence_type,
                                       // [6] dispatch, [7] forward, [15:8] length
    output logic            m_tuser,   // [0] out_link
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [1:0] cfg_data
);
    import nsr_pkg::*;

    logic        in_valid_reg;
    logic        in_link_reg;
    logic [7:0]  in_char_reg;
    link_state_t link_st_reg [2];
    route_cfg_t  cfg_reg;
    logic        out_valid_reg;
    logic        out_link_reg;
    result_t     out_res_reg;

    link_state_t st_next;
    logic        step_res_valid;
    result_t     step_res;
    logic        out_stall;
    logic        advance;

    assign out_stall = out_valid_reg && !m_tready;
    assign advance   = in_valid_reg && !out_stall;
    assign s_tready  = !in_valid_reg || advance;

    nsr_char_step u_step (
        .st        (link_st_reg[in_link_reg]),
        .link      (in_link_reg),
        .ch        (in_char_reg),
        .cfg       (cfg_reg),
        .st_next   (st_next),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_link_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_st_reg[0] <= '0;
            link_st_reg[1] <= '0;
        end else if (advance) begin
            link_st_reg[in_link_reg] <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_stall) begin
            out_valid_reg <= advance && step_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res_valid) begin
            out_link_reg <= in_link_reg;
            out_res_reg  <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nav     <= 2'd0;
            cfg_reg.gnss    <= 2'd1;
            cfg_reg.wind    <= 2'd2;
            cfg_reg.depth   <= 2'd2;
            cfg_reg.speed   <= 2'd2;
            cfg_reg.compass <= 2'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NAV:     cfg_reg.nav     <= cfg_data;
                CFG_GNSS:    cfg_reg.gnss    <= cfg_data;
                CFG_WIND:    cfg_reg.wind    <= cfg_data;
                CFG_DEPTH:   cfg_reg.depth   <= cfg_data;
                CFG_SPEED:   cfg_reg.speed   <= cfg_data;
                CFG_COMPASS: cfg_reg.compass <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_link_reg;
    assign m_tdata  = {out_res_reg.length, out_res_reg.forward, out_res_reg.dispatch,
                       out_res_reg.sentence_type, out_res_reg.status};

endmodule

`default_nettype wire

// ===== hw/rtl/nsr_char_step.sv =====
// Per-character framing update for one link: next state and optional result.
// Depends on nsr_pkg.
`default_nettype none

module nsr_char_step (
    input  wire nsr_pkg::link_state_t st,
    input  wire logic                 link,
    input  wire logic [7:0]           ch,
    input  wire nsr_pkg::route_cfg_t  cfg,
    output nsr_pkg::link_state_t      st_next,
    output logic                      res_valid,
    output nsr_pkg::result_t          res
);
    import nsr_pkg::*;

    logic [4:0] nib;
    logic [7:0] count_inc;
    stype_t     ty;
    status_t    stat;
    logic       disp;

    assign nib       = hex_value(ch);
    assign count_inc = st.char_count + 8'd1;
    assign ty        = decode_type(st.type_chars);

    always_comb begin
        if (st.char_count < LEN_MIN || st.char_count >= LEN_LIMIT) begin
            stat = ST_LENGTH;
        end else if (st.star_seen && st.digits_after_star == 2'd2 && !st.digit_error
                     && st.checksum_digits == st.xor_at_star) begin
            stat = ST_VALID;
        end else begin
            stat = ST_CHECKSUM;
        end
        disp = (stat == ST_VALID) && (ty != TY_UNKNOWN)
               && (source_of(ty, cfg) == {1'b0, link});
    end

    always_comb begin
        res.status        = stat;
        res.sentence_type = ty;
        res.dispatch      = disp;
        res.forward       = disp && (ty == TY_RMC || ty == TY_GGA || ty == TY_VTG);
        res.length        = st.char_count;
    end

    always_comb begin
        st_next   = st;
        res_valid = 1'b0;
        if (ch == CH_DOLLAR) begin
            st_next             = '0;
            st_next.in_sentence = 1'b1;
            st_next.char_count  = 8'd1;
        end else if (st.in_sentence) begin
            if (ch == CH_CR) begin
                res_valid           = 1'b1;
                st_next.in_sentence = 1'b0;
            end else begin
                // positions 3..5 carry the sentence type
                if (st.char_count >= 8'd3 && st.char_count <= 8'd5) begin
                    st_next.type_chars = {st.type_chars[15:0], ch};
                end
                if (ch == CH_STAR) begin
                    st_next.xor_at_star       = st.running_xor;
                    st_next.star_seen         = 1'b1;
                    st_next.digits_after_star = 2'd0;
                    st_next.checksum_digits   = 8'd0;
                    st_next.digit_error       = 1'b0;
                end else if (st.star_seen && st.digits_after_star != 2'd2) begin
                    st_next.checksum_digits   = {st.checksum_digits[3:0],
                                                 nib[4] ? 4'd0 : nib[3:0]};
                    st_next.digit_error       = st.digit_error | nib[4];
                    st_next.digits_after_star = st.digits_after_star + 2'd1;
                end
                st_next.running_xor = st.running_xor ^ ch;
                st_next.char_count  = count_inc;
                // overflow: drop silently
                if (count_inc >= MAX_LEN_C) begin
                    st_next.in_sentence = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nsr_checker.sv =====
// Port-level checks for nmea_sentence_receiver, bound to the top level.
// Depends on nsr_pkg and nmea_sentence_receiver_macros.svh.
`default_nettype none
`include "nmea_sentence_receiver_macros.svh"

module nsr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);
    import nsr_pkg::*;

    // a held item keeps its payload
    `NSR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `NSR_ASSERT(a_fwd_needs_disp, aclk, aresetn, !(m_tvalid && m_tdata[7]) || m_tdata[6])
    `NSR_ASSERT(a_disp_valid_known, aclk, aresetn, !(m_tvalid && m_tdata[6]) || (m_tdata[1:0] == ST_VALID && m_tdata[5:2] != TY_UNKNOWN))
    // length status exactly when the count is out of range
    `NSR_ASSERT(a_len_status, aclk, aresetn, !m_tvalid || ((m_tdata[1:0] == ST_LENGTH) == (m_tdata[15:8] < LEN_MIN || m_tdata[15:8] >= LEN_LIMIT)))
    `NSR_ASSERT(a_status_code, aclk, aresetn, !m_tvalid || m_tdata[1:0] != 2'd3)

endmodule

bind nmea_sentence_receiver nsr_checker u_nsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
